// ===== hw/rtl/oltab_pkg.sv =====
// Shared types and constants for the ordered list table engine.
// No dependencies; the other files use scoped names, the testbench imports it.
`timescale 1ns / 1ps

package oltab_pkg;

  // Fixed payload widths of the request and response channels
  localparam int CMD_W     = 3;
  localparam int POS_IN_W  = 7;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int POS_OUT_W = 6;
  localparam int COUNT_W   = 7;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_APPEND       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE_AT    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE_VALUE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FIND_FIRST   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FIND_LAST    = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

  // What every cell does with its word this cycle
  typedef enum logic [1:0] {
    D_HOLD,
    D_INSERT,   // cells above pos take left neighbor, cell at pos takes value
    D_DELETE    // cells at and above pos take right neighbor
  } data_op_t;

  // What every cell does with its match flag this cycle
  typedef enum logic [1:0] {
    F_HOLD,
    F_CAPTURE,     // flag = word matches value and cell is in use
    F_SHIFT_DOWN,  // flag moves toward cell 0
    F_SHIFT_UP     // flag moves toward the top cell
  } flag_op_t;

  typedef struct packed {
    data_op_t data_op;
    flag_op_t flag_op;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/oltab_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on oltab_pkg for the payload widths.
`timescale 1ns / 1ps

interface oltab_in_if;
  logic                          valid;
  logic                          ready;
  logic [oltab_pkg::CMD_W-1:0]    cmd;
  logic [oltab_pkg::POS_IN_W-1:0] position_in;
  logic [oltab_pkg::VALUE_W-1:0]  item_value;

  modport source (output valid, output cmd, output position_in, output item_value,
                  input ready);
  modport sink   (input valid, input cmd, input position_in, input item_value,
                  output ready);
endinterface

interface oltab_out_if;
  logic                           valid;
  logic                           ready;
  logic [oltab_pkg::STATUS_W-1:0]  status;
  logic [oltab_pkg::POS_OUT_W-1:0] position_out;
  logic [oltab_pkg::COUNT_W-1:0]   entry_count;

  modport source (output valid, output status, output position_out, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input position_out, input entry_count,
                  output ready);
endinterface

// ===== hw/rtl/oltab_cell.sv =====
// One list cell: holds one entry word and one match flag, trades both with
// its neighbors under a broadcast control word. Depends on oltab_pkg.
`timescale 1ns / 1ps

module oltab_cell #(
  parameter int INDEX     = 0,
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                         clk,
  input  oltab_pkg::cell_ctrl_t        ctrl,
  input  logic [$clog2(DEPTH)-1:0]     pos,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  input  logic [WORD_BITS-1:0]         value,
  input  logic [WORD_BITS-1:0]         left_data,
  input  logic [WORD_BITS-1:0]         right_data,
  input  logic                         left_flag,
  input  logic                         right_flag,
  output logic [WORD_BITS-1:0]         data,
  output logic                         flag
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

  logic in_use;
  assign in_use = MY_CNT < count;

  always_ff @(posedge clk) begin
    case (ctrl.data_op)
      oltab_pkg::D_INSERT: begin
        if (MY_IDX > pos) begin
          data <= left_data;
        end else if (MY_IDX == pos) begin
          data <= value;
        end
      end
      oltab_pkg::D_DELETE: begin
        if (MY_IDX >= pos) begin
          data <= right_data;
        end
      end
      default: begin
      end
    endcase

    case (ctrl.flag_op)
      oltab_pkg::F_CAPTURE:    flag <= in_use && (data == value);
      oltab_pkg::F_SHIFT_DOWN: flag <= right_flag;
      oltab_pkg::F_SHIFT_UP:   flag <= left_flag;
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/ordered_list_table_engine_top.sv =====
// Top level of the ordered list table engine: command sequencer, count and
// response register around a chain of oltab_cell. Depends on oltab_pkg, oltab_if.
`timescale 1ns / 1ps

// Channel  Modport             Payload
// req      oltab_in_if.sink    cmd, position_in, item_value
// rsp      oltab_out_if.source status, position_out, entry_count
//
// Append, insert, delete at index and unused codes: accepted in S_IDLE, then
// answered from S_EXEC, shifting the whole cell chain once when the list changes.
// Searches: S_EXEC captures the match flags, S_SCAN walks them one cell per cycle
// toward the end cell, then S_FINISH responds; a miss with no flags skips the walk.
// Reset (rst, synchronous) clears the count; entries need no clearing.
// A response waiting on rsp holds the command in its final step; the next
// request can be taken while the previous response is still pending.

module ordered_list_table_engine_top #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  oltab_in_if.sink         req,
  oltab_out_if.source      rsp
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > oltab_pkg::POS_IN_W) ? CNT_W : oltab_pkg::POS_IN_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] TOP_IDX  = IDX_W'(DEPTH - 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_FINISH} state_t;

  state_t                        state;
  logic [oltab_pkg::CMD_W-1:0]   cmd;
  logic [CMP_W-1:0]              pos_req;
  logic [WORD_BITS-1:0]          value;
  logic [CNT_W-1:0]              count;
  logic [IDX_W-1:0]              steps;
  logic [IDX_W-1:0]              hit_pos;
  logic                          found;
  logic                          rsp_valid;
  logic [oltab_pkg::STATUS_W-1:0]  rsp_status;
  logic [oltab_pkg::POS_OUT_W-1:0] rsp_position;
  logic [oltab_pkg::COUNT_W-1:0]   rsp_count;

  logic [63:0]               item_wide;
  logic [CMP_W-1:0]          count_ext;
  logic                      slot_free;
  logic                      search_last;
  logic                      head_flag;
  logic                      any_flag;

  oltab_pkg::cell_ctrl_t     ctrl;
  logic [IDX_W-1:0]          cell_pos;
  logic                      res_fire;
  logic [oltab_pkg::STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]          res_pos;
  logic [CNT_W-1:0]          res_count;
  logic [CMP_W-1:0]          res_pos_ext;
  logic [CMP_W-1:0]          res_count_ext;

  logic [WORD_BITS-1:0]      cell_data [DEPTH];
  logic [DEPTH-1:0]          flags;

  assign item_wide   = 64'(req.item_value);
  assign count_ext   = CMP_W'(count);
  assign slot_free   = !rsp_valid || rsp.ready;
  assign search_last = (cmd == oltab_pkg::CMD_FIND_LAST);
  assign head_flag   = search_last ? flags[DEPTH-1] : flags[0];
  assign any_flag    = |flags;

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.position_out = rsp_position;
  assign rsp.entry_count  = rsp_count;

  always_comb begin
    ctrl       = '{data_op: oltab_pkg::D_HOLD, flag_op: oltab_pkg::F_HOLD};
    cell_pos   = '0;
    res_fire   = 1'b0;
    res_status = oltab_pkg::ST_OK;
    res_pos    = '0;
    res_count  = count;
    case (state)
      S_EXEC: begin
        case (cmd)
          oltab_pkg::CMD_APPEND: begin
            res_fire = slot_free;
            if (count == FULL_CNT) begin
              res_status = oltab_pkg::ST_FULL;
            end else begin
              res_pos   = count[IDX_W-1:0];
              res_count = count + 1'b1;
              cell_pos  = count[IDX_W-1:0];
              if (slot_free) ctrl.data_op = oltab_pkg::D_INSERT;
            end
          end
          oltab_pkg::CMD_INSERT: begin
            res_fire = slot_free;
            if (pos_req > count_ext) begin
              res_status = oltab_pkg::ST_RANGE;
            end else if (count == FULL_CNT) begin
              res_status = oltab_pkg::ST_FULL;
            end else begin
              res_pos   = pos_req[IDX_W-1:0];
              res_count = count + 1'b1;
              cell_pos  = pos_req[IDX_W-1:0];
              if (slot_free) ctrl.data_op = oltab_pkg::D_INSERT;
            end
          end
          oltab_pkg::CMD_DELETE_AT: begin
            res_fire = slot_free;
            if (pos_req >= count_ext) begin
              res_status = oltab_pkg::ST_RANGE;
            end else begin
              res_pos   = pos_req[IDX_W-1:0];
              res_count = count - 1'b1;
              cell_pos  = pos_req[IDX_W-1:0];
              if (slot_free) ctrl.data_op = oltab_pkg::D_DELETE;
            end
          end
          oltab_pkg::CMD_DELETE_VALUE,
          oltab_pkg::CMD_FIND_FIRST,
          oltab_pkg::CMD_FIND_LAST: begin
            ctrl.flag_op = oltab_pkg::F_CAPTURE;
          end
          default: begin
            res_fire = slot_free;
          end
        endcase
      end
      S_SCAN: begin
        if (!head_flag && any_flag) begin
          ctrl.flag_op = search_last ? oltab_pkg::F_SHIFT_UP : oltab_pkg::F_SHIFT_DOWN;
        end
      end
      S_FINISH: begin
        res_fire = slot_free;
        if (found) begin
          res_pos = hit_pos;
          if (cmd == oltab_pkg::CMD_DELETE_VALUE) begin
            res_count = count - 1'b1;
            cell_pos  = hit_pos;
            if (slot_free) ctrl.data_op = oltab_pkg::D_DELETE;
          end
        end else begin
          res_status = oltab_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_pos_ext   = CMP_W'(res_pos);
  assign res_count_ext = CMP_W'(res_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      found     <= 1'b0;
      steps     <= '0;
    end else begin
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (res_fire) begin
        rsp_valid    <= 1'b1;
        rsp_status   <= res_status;
        rsp_position <= res_pos_ext[oltab_pkg::POS_OUT_W-1:0];
        rsp_count    <= res_count_ext[oltab_pkg::COUNT_W-1:0];
        count        <= res_count;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd     <= req.cmd;
            pos_req <= CMP_W'(req.position_in);
            value   <= item_wide[WORD_BITS-1:0];
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          steps <= '0;
          if (ctrl.flag_op == oltab_pkg::F_CAPTURE) begin
            state <= S_SCAN;
          end else if (res_fire) begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (head_flag) begin
            found   <= 1'b1;
            hit_pos <= search_last ? (TOP_IDX - steps) : steps;
            state   <= S_FINISH;
          end else if (!any_flag) begin
            found <= 1'b0;
            state <= S_FINISH;
          end else begin
            steps <= steps + 1'b1;
          end
        end
        S_FINISH: begin
          if (res_fire) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Cell chain: neighbors exchange words on shifts and flags during scans
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_data;
    logic [WORD_BITS-1:0] right_data;
    logic                 left_flag;
    logic                 right_flag;

    if (i == 0) begin : g_bottom
      assign left_data = cell_data[i];
      assign left_flag = 1'b0;
    end else begin : g_mid_lo
      assign left_data = cell_data[i-1];
      assign left_flag = flags[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign right_data = cell_data[i];
      assign right_flag = 1'b0;
    end else begin : g_mid_hi
      assign right_data = cell_data[i+1];
      assign right_flag = flags[i+1];
    end

    oltab_cell #(
      .INDEX     (i),
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (cell_pos),
      .count      (count),
      .value      (value),
      .left_data  (left_data),
      .right_data (right_data),
      .left_flag  (left_flag),
      .right_flag (right_flag),
      .data       (cell_data[i]),
      .flag       (flags[i])
    );
  end

endmodule

// ===== tb/ordered_list_table_engine_top_test.sv =====
// Self-checking testbench for the ordered list table engine (append, insert, delete, search).
// Depends on oltab_pkg and the oltab_in_if / oltab_out_if channel interfaces.
`timescale 1ns / 1ps

module ordered_list_table_engine_top_test;
  import oltab_pkg::*;

  localparam int LIST_DEPTH = 64;
  localparam int WORD_W     = 32;
  localparam int SETTLE_CYC = LIST_DEPTH + 16;

  // Codes 6 and 7 are not assigned; the block answers them as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [POS_OUT_W-1:0] position;
    logic [COUNT_W-1:0]   count;
  } list_result_t;

  logic clk;
  logic rst;

  oltab_in_if  req_ch ();
  oltab_out_if rsp_ch ();

  ordered_list_table_engine_top #(
    .DEPTH     (LIST_DEPTH),
    .WORD_BITS (WORD_W)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the list, entry 0 first
  logic [WORD_W-1:0] list_words[$];
  list_result_t      pending_results[$];

  bit idle_on         = 1'b1;
  int hold_off_cycles = 0;
  int mismatches      = 0;
  int commands_sent   = 0;
  int responses_seen  = 0;
  int peak_fill       = 0;
  int status_seen[4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("ordered_list_table_engine_top_test failed");
    $finish;
  end

  // Next list state and response for one command
  function automatic list_result_t predict_list_op(input logic [CMD_W-1:0] op,
                                                   input logic [POS_IN_W-1:0] pos,
                                                   input logic [WORD_W-1:0] word);
    list_result_t r;
    int at;
    at = -1;
    r.status = ST_OK;
    r.position = '0;
    case (op)
      CMD_APPEND: begin
        if (list_words.size() >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          r.position = POS_OUT_W'(list_words.size());
          list_words.push_back(word);
        end
      end
      CMD_INSERT: begin
        // range check wins over full
        if (int'(pos) > list_words.size()) begin
          r.status = ST_RANGE;
        end else if (list_words.size() >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_words.insert(int'(pos), word);
          r.position = POS_OUT_W'(pos);
        end
      end
      CMD_DELETE_AT: begin
        if (int'(pos) >= list_words.size()) begin
          r.status = ST_RANGE;
        end else begin
          list_words.delete(int'(pos));
          r.position = POS_OUT_W'(pos);
        end
      end
      CMD_DELETE_VALUE, CMD_FIND_FIRST: begin
        foreach (list_words[i])
          if (at < 0 && list_words[i] == word) at = i;
        if (at < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.position = POS_OUT_W'(at);
          if (op == CMD_DELETE_VALUE) list_words.delete(at);
        end
      end
      CMD_FIND_LAST: begin
        foreach (list_words[i])
          if (list_words[i] == word) at = i;
        if (at < 0) r.status = ST_NOT_FOUND;
        else r.position = POS_OUT_W'(at);
      end
      default: ;
    endcase
    r.count = COUNT_W'(list_words.size());
    return r;
  endfunction

  // Biased toward words already held so deletes and searches hit often
  function automatic logic [WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && list_words.size() > 0)
      return list_words[$urandom_range(0, list_words.size() - 1)];
    if (r < 75) return WORD_W'($urandom_range(0, 7));
    return $urandom;
  endfunction

  task automatic send_command(input logic [CMD_W-1:0] op, input logic [POS_IN_W-1:0] pos,
                              input logic [WORD_W-1:0] word);
    int gap;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.cmd         <= op;
    req_ch.position_in <= pos;
    req_ch.item_value  <= word;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_results.push_back(predict_list_op(op, pos, word));
    commands_sent++;
    if (list_words.size() > peak_fill) peak_fill = list_words.size();
  endtask

  task automatic send_random_op(input int grow_bias);
    logic [CMD_W-1:0]    op;
    logic [POS_IN_W-1:0] pos;
    int r;
    int fill;
    fill = list_words.size();
    r = $urandom_range(0, 99);
    if (r < grow_bias) begin
      op = $urandom_range(0, 1) ? CMD_INSERT : CMD_APPEND;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) op = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
      else if (r < 27) op = CMD_DELETE_AT;
      else if (r < 51) op = CMD_DELETE_VALUE;
      else if (r < 75) op = CMD_FIND_FIRST;
      else op = CMD_FIND_LAST;
    end
    // mostly legal indices, some just past the end, a few anywhere in the field
    r = $urandom_range(0, 99);
    if (r < 85) pos = POS_IN_W'($urandom_range(0, fill));
    else if (r < 93) pos = POS_IN_W'(fill + $urandom_range(1, 3));
    else pos = POS_IN_W'($urandom_range(0, 127));
    send_command(op, pos, pick_word());
  endtask

  task automatic wait_for_responses();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_basics();
    send_command(CMD_FIND_FIRST, 7'd0, 32'h0000_0000);
    send_command(CMD_FIND_LAST, 7'd0, 32'hFFFF_FFFF);
    send_command(CMD_DELETE_VALUE, 7'd0, 32'h0000_0000);
    send_command(CMD_DELETE_AT, 7'd0, 32'h0000_0000);
    send_command(CMD_INSERT, 7'd1, 32'h1234_5678);
    send_command(CMD_INSERT, 7'd127, 32'hFFFF_FFFF);
    send_command(CMD_INSERT, 7'd0, 32'hFFFF_FFFF);
    send_command(CMD_APPEND, 7'd127, 32'h0000_0000);
    send_command(CMD_APPEND, 7'd0, 32'h5A5A_5A5A);
    send_command(CMD_INSERT, 7'd1, 32'h5A5A_5A5A);
    send_command(CMD_INSERT, 7'd4, 32'h0000_0000);    // index equal to count appends
    send_command(CMD_FIND_FIRST, 7'd0, 32'h5A5A_5A5A);
    send_command(CMD_FIND_LAST, 7'd0, 32'h5A5A_5A5A);
    send_command(CMD_FIND_FIRST, 7'd0, 32'h0000_0000);
    send_command(CMD_FIND_LAST, 7'd0, 32'h0000_0000);
    send_command(CMD_FIND_LAST, 7'd0, 32'hA5A5_A5A5);
    send_command(CMD_DELETE_VALUE, 7'd0, 32'h5A5A_5A5A);
    send_command(CMD_DELETE_AT, 7'd0, 32'h0000_0000);
    send_command(CMD_DELETE_AT, 7'd127, 32'h0000_0000);
    send_command(CMD_DELETE_AT, 7'd3, 32'h0000_0000);
    send_command(CMD_SPARE_LO, 7'd0, 32'h0000_0000);
    send_command(CMD_SPARE_HI, 7'd127, 32'hFFFF_FFFF);
  endtask

  task automatic test_capacity();
    logic [WORD_W-1:0] top_word;
    while (list_words.size() < LIST_DEPTH) send_command(CMD_APPEND, 7'd0, pick_word());
    top_word = list_words[LIST_DEPTH - 1];
    send_command(CMD_APPEND, 7'd0, 32'hDEAD_BEEF);
    send_command(CMD_INSERT, 7'd64, 32'hDEAD_BEEF);
    send_command(CMD_INSERT, 7'd0, 32'hDEAD_BEEF);
    send_command(CMD_INSERT, 7'd65, 32'hDEAD_BEEF);
    send_command(CMD_INSERT, 7'd127, 32'hDEAD_BEEF);
    send_command(CMD_DELETE_AT, 7'd64, 32'h0000_0000);
    send_command(CMD_FIND_LAST, 7'd0, top_word);
    send_command(CMD_DELETE_AT, 7'd63, 32'h0000_0000);
    send_command(CMD_INSERT, 7'd63, 32'hFFFF_FFFF);
    send_command(CMD_FIND_FIRST, 7'd0, 32'hFFFF_FFFF);
    send_command(CMD_DELETE_AT, 7'd0, 32'h0000_0000);
    send_command(CMD_INSERT, 7'd0, 32'h0000_0001);
  endtask

  // Receiver stalls for a long stretch while commands keep coming back to back
  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_off_cycles = 300;
    repeat (40) send_random_op(50);
    idle_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (15) send_random_op(55);
    wait_for_responses();
    repeat (15) send_random_op(45);
  endtask

  // Phases alternate between growing, steady and shrinking lists
  task automatic test_random_mix();
    for (int phase = 0; phase < 9; phase++) begin
      idle_on = (phase != 4);
      repeat (100) send_random_op(phase % 3 == 0 ? 75 : (phase % 3 == 1 ? 45 : 20));
    end
    idle_on = 1'b1;
  endtask

  initial begin : rsp_sink
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = (hold_off_cycles > 0) ? hold_off_cycles : (idle_on ? $urandom_range(0, 12) : 0);
      hold_off_cycles = 0;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : rsp_check
    list_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      responses_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected response: status %0d position %0d count %0d",
               rsp_ch.status, rsp_ch.position_out, rsp_ch.entry_count);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        status_seen[want.status]++;
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          mismatches++;
        end
        if (rsp_ch.position_out !== want.position) begin
          $error("position_out: expected %0d, got %0d", want.position, rsp_ch.position_out);
          mismatches++;
        end
        if (rsp_ch.entry_count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, rsp_ch.entry_count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    req_ch.valid       <= 1'b0;
    req_ch.cmd         <= CMD_APPEND;
    req_ch.position_in <= '0;
    req_ch.item_value  <= '0;
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed_basics();
    test_capacity();
    test_backpressure();
    test_drain_pause();
    test_random_mix();

    wait_for_responses();
    repeat (SETTLE_CYC) @(posedge clk);

    $display("%0d commands, %0d responses; list peaked at %0d of %0d entries",
             commands_sent, responses_seen, peak_fill, LIST_DEPTH);
    $display("status mix: ok %0d, full %0d, not found %0d, out of range %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NOT_FOUND],
             status_seen[ST_RANGE]);
    if (mismatches == 0) begin
      $display("ordered_list_table_engine_top_test passed");
    end else begin
      $display("ordered_list_table_engine_top_test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/oltab_pkg.sv
hw/rtl/oltab_if.sv
hw/rtl/oltab_cell.sv
hw/rtl/ordered_list_table_engine_top.sv
tb/ordered_list_table_engine_top_test.sv
